>>> rtl/delta_timeout_queue_assert.svh
// Assertion macros for the delta timeout queue.
// Included by the top level; no other dependencies.
`ifndef DELTA_TIMEOUT_QUEUE_ASSERT_SVH
`define DELTA_TIMEOUT_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
`define DTQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dtq assertion failed");
`define DTQ_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("dtq assertion failed");
`else
`define DTQ_ASSERT(label, clk, rst_n, prop)
`define DTQ_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

>>> rtl/dtq_pkg.sv
// Shared types and constants of the delta timeout queue.
// No dependencies.
package dtq_pkg;

  localparam int unsigned DefCapacity  = 16;
  localparam int unsigned DefTickWidth = 16;
  localparam int unsigned DefIdWidth   = 16;
  localparam int unsigned PortIdWidth   = 16;
  localparam int unsigned PortTickWidth = 16;
  localparam int unsigned OccWidth      = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_CANCEL = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_ZERO_WAIT = 3'd2,
    ST_EXPIRED   = 3'd3,
    ST_CANCELLED = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_TICK_NONE = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_TICK,
    OP_INSERT,
    OP_REMOVE
  } op_e;

  typedef enum logic {
    S_IDLE,
    S_EXPIRE
  } state_e;

  typedef struct packed {
    op_e  op;
    logic pop;
  } cell_ctl_t;

endpackage

>>> rtl/dtq_cell.sv
// One queue cell: waiter id, remaining ticks to its deadline, valid bit.
// Depends on dtq_pkg.
module dtq_cell #(
  parameter int unsigned TICK_WIDTH = dtq_pkg::DefTickWidth,
  parameter int unsigned ID_WIDTH   = dtq_pkg::DefIdWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dtq_pkg::cell_ctl_t    ctl_i,
  input  logic [ID_WIDTH-1:0]   new_id_i,
  input  logic [TICK_WIDTH-1:0] new_cum_i,
  input  logic                  left_le_i,
  input  logic                  left_valid_i,
  input  logic [ID_WIDTH-1:0]   left_id_i,
  input  logic [TICK_WIDTH-1:0] left_cum_i,
  input  logic                  right_valid_i,
  input  logic [ID_WIDTH-1:0]   right_id_i,
  input  logic [TICK_WIDTH-1:0] right_cum_i,
  input  logic                  hit_i,
  output logic                  hit_o,
  output logic                  le_o,
  output logic                  valid_o,
  output logic [ID_WIDTH-1:0]   id_o,
  output logic [TICK_WIDTH-1:0] cum_o
);
  import dtq_pkg::*;

  logic                  valid_q, valid_d;
  logic [ID_WIDTH-1:0]   id_q, id_d;
  logic [TICK_WIDTH-1:0] cum_q, cum_d;

  assign le_o  = valid_q && (cum_q <= new_cum_i);
  assign hit_o = hit_i || (valid_q && (id_q == new_id_i));

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    cum_d   = cum_q;
    unique case (ctl_i.op)
      OP_TICK: begin
        if (cum_q != '0) cum_d = cum_q - TICK_WIDTH'(1);
      end
      OP_INSERT: begin
        if (!le_o) begin
          if (left_le_i) begin
            valid_d = 1'b1;
            id_d    = new_id_i;
            cum_d   = new_cum_i;
          end else begin
            valid_d = left_valid_i;
            id_d    = left_id_i;
            cum_d   = left_cum_i;
          end
        end
      end
      OP_REMOVE: begin
        if (hit_o || ctl_i.pop) begin
          valid_d = right_valid_i;
          id_d    = right_id_i;
          cum_d   = right_cum_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    cum_q <= cum_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign cum_o   = cum_q;

endmodule

>>> rtl/delta_timeout_queue.sv
// Top level of the delta timeout queue: a chain of dtq_cell with a control FSM.
// Depends on dtq_pkg, dtq_cell and delta_timeout_queue_assert.svh.
//
//   channel | signals                                         | dir
//   in      | in_valid_i, in_ready_o, command_i, waiter_id_i, | in
//           | wait_ticks_i                                    |
//   out     | out_valid_o, out_ready_i, status_o,             | out
//           | result_id_o, last_o, occupancy_o                |
//
// Insert, cancel, rejects and ticks without expiry: one output beat per item.
// A tick that expires N waiters: N beats, one pop per cycle while output is free.
// Cells hold remaining ticks to each deadline, so a tick updates all cells at once.
// Reset clears all valid bits and the count; no clearing pass.
// A held output beat stalls acceptance and further expiry pops.
module delta_timeout_queue #(
  parameter int unsigned CAPACITY   = dtq_pkg::DefCapacity,
  parameter int unsigned TICK_WIDTH = dtq_pkg::DefTickWidth,
  parameter int unsigned ID_WIDTH   = dtq_pkg::DefIdWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        command_i,
  input  logic [dtq_pkg::PortIdWidth-1:0]   waiter_id_i,
  input  logic [dtq_pkg::PortTickWidth-1:0] wait_ticks_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        status_o,
  output logic [dtq_pkg::PortIdWidth-1:0]   result_id_o,
  output logic                              last_o,
  output logic [dtq_pkg::OccWidth-1:0]      occupancy_o
);
  import dtq_pkg::*;
  `include "delta_timeout_queue_assert.svh"

  localparam int unsigned CntWidth = $clog2(CAPACITY + 1);

  logic [CAPACITY-1:0]                 valid;
  logic [CAPACITY-1:0]                 le;
  logic [CAPACITY:0]                   hit;
  logic [CAPACITY-1:0][ID_WIDTH-1:0]   ids;
  logic [CAPACITY-1:0][TICK_WIDTH-1:0] cums;

  logic [ID_WIDTH-1:0]   id_in;
  logic [TICK_WIDTH-1:0] wait_in;
  cell_ctl_t             ctl;

  state_e              state_q, state_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic                out_valid_q, out_load;
  status_e             status_q, status_d;
  logic [ID_WIDTH-1:0] rid_q, rid_d;
  logic                last_q, last_d;
  logic [CntWidth-1:0] occ_q;
  logic                out_free, accept;

  assign id_in   = ID_WIDTH'(waiter_id_i);
  assign wait_in = TICK_WIDTH'(wait_ticks_i);
  assign hit[0]  = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  l_le, l_valid, r_valid;
    logic [ID_WIDTH-1:0]   l_id, r_id;
    logic [TICK_WIDTH-1:0] l_cum, r_cum;
    if (i == 0) begin : g_first
      assign l_le    = 1'b1;
      assign l_valid = 1'b0;
      assign l_id    = '0;
      assign l_cum   = '0;
    end else begin : g_mid
      assign l_le    = le[i-1];
      assign l_valid = valid[i-1];
      assign l_id    = ids[i-1];
      assign l_cum   = cums[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_id    = '0;
      assign r_cum   = '0;
    end else begin : g_inner
      assign r_valid = valid[i+1];
      assign r_id    = ids[i+1];
      assign r_cum   = cums[i+1];
    end
    dtq_cell #(
      .TICK_WIDTH(TICK_WIDTH),
      .ID_WIDTH  (ID_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .new_id_i     (id_in),
      .new_cum_i    (wait_in),
      .left_le_i    (l_le),
      .left_valid_i (l_valid),
      .left_id_i    (l_id),
      .left_cum_i   (l_cum),
      .right_valid_i(r_valid),
      .right_id_i   (r_id),
      .right_cum_i  (r_cum),
      .hit_i        (hit[i]),
      .hit_o        (hit[i+1]),
      .le_o         (le[i]),
      .valid_o      (valid[i]),
      .id_o         (ids[i]),
      .cum_o        (cums[i])
    );
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ctl.op   = OP_HOLD;
    ctl.pop  = 1'b0;
    out_load = 1'b0;
    status_d = ST_NOT_FOUND;
    rid_d    = '0;
    last_d   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          unique case (command_i)
            CMD_INSERT: begin
              if (wait_in == '0) begin
                status_d = ST_ZERO_WAIT;
              end else if (count_q == CntWidth'(CAPACITY)) begin
                status_d = ST_FULL;
              end else begin
                ctl.op   = OP_INSERT;
                count_d  = count_q + CntWidth'(1);
                status_d = ST_INSERTED;
                rid_d    = id_in;
              end
            end
            CMD_TICK: begin
              status_d = ST_TICK_NONE;
              if (count_q != '0) begin
                ctl.op = OP_TICK;
                if (cums[0] <= TICK_WIDTH'(1)) begin
                  out_load = 1'b0;
                  state_d  = S_EXPIRE;
                end
              end
            end
            CMD_CANCEL: begin
              if (hit[CAPACITY]) begin
                ctl.op   = OP_REMOVE;
                count_d  = count_q - CntWidth'(1);
                status_d = ST_CANCELLED;
                rid_d    = id_in;
              end
            end
            default: ;
          endcase
        end
      end
      S_EXPIRE: begin
        if (out_free) begin
          out_load = 1'b1;
          ctl.op   = OP_REMOVE;
          ctl.pop  = 1'b1;
          count_d  = count_q - CntWidth'(1);
          status_d = ST_EXPIRED;
          rid_d    = ids[0];
          last_d   = (count_q == CntWidth'(1)) || (cums[1] != '0);
          if (last_d) state_d = S_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= status_d;
      rid_q    <= rid_d;
      last_q   <= last_d;
      occ_q    <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign result_id_o = PortIdWidth'(rid_q);
  assign last_o      = last_q;
  assign occupancy_o = OccWidth'(occ_q);

  `DTQ_ASSERT(a_count_max, clk_i, rst_ni, count_q <= CntWidth'(CAPACITY))
  `DTQ_ASSERT(a_valid_count, clk_i, rst_ni, $countones(valid) == int'(count_q))
  `DTQ_ASSERT(a_expire_nonempty, clk_i, rst_ni, state_q != S_EXPIRE || count_q != '0)
  `DTQ_ASSERT_NEXT(a_load_valid, clk_i, rst_ni, out_load, out_valid_q)

endmodule

>>> verif/tb_delta_timeout_queue.sv
// Self-checking testbench for the delta timeout queue: directed and random
// insert/tick/cancel beats, predicted in a local delta-list model. Depends on dtq_pkg.
module tb_delta_timeout_queue;
  import dtq_pkg::*;

  localparam int Cap = 16;

  typedef struct packed {
    status_e     st;
    logic [15:0] id;
    logic        fin;
    logic [4:0]  occ;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = '0;
  logic [15:0] waiter_id_i = '0;
  logic [15:0] wait_ticks_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] result_id_o;
  logic        last_o;
  logic [4:0]  occupancy_o;

  delta_timeout_queue dut (.*);

  always #2 clk_i = ~clk_i;

  logic [15:0] q_id [Cap];
  logic [15:0] q_dl [Cap];
  int          q_cnt = 0;
  beat_t       pending_q[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;

  function automatic beat_t mk(status_e s, logic [15:0] i, logic f);
    beat_t b;
    b.st = s; b.id = i; b.fin = f; b.occ = 5'(q_cnt);
    return b;
  endfunction

  task automatic drop_at(int p);
    for (int i = p; i + 1 < q_cnt; i++) begin
      q_id[i] = q_id[i+1];
      q_dl[i] = q_dl[i+1];
    end
    q_cnt--;
  endtask

  task automatic predict_queue(logic [1:0] c, logic [15:0] id, logic [15:0] w);
    int          p;
    int unsigned sum;
    logic [16:0] s;
    case (c)
      CMD_INSERT: begin
        if (w == 0) pending_q.push_back(mk(ST_ZERO_WAIT, 0, 1));
        else if (q_cnt >= Cap) pending_q.push_back(mk(ST_FULL, 0, 1));
        else begin
          p = 0; sum = 0;
          while (p < q_cnt && sum + q_dl[p] <= w) begin
            sum += q_dl[p]; p++;
          end
          for (int i = q_cnt; i > p; i--) begin
            q_id[i] = q_id[i-1]; q_dl[i] = q_dl[i-1];
          end
          q_id[p] = id;
          q_dl[p] = 16'(w - sum);
          q_cnt++;
          if (p + 1 < q_cnt)
            q_dl[p+1] = q_dl[p+1] >= q_dl[p] ? q_dl[p+1] - q_dl[p] : 16'd0;
          pending_q.push_back(mk(ST_INSERTED, id, 1));
        end
      end
      CMD_TICK: begin
        if (q_cnt == 0) pending_q.push_back(mk(ST_TICK_NONE, 0, 1));
        else begin
          if (q_dl[0] > 0) q_dl[0]--;
          if (q_dl[0] != 0) pending_q.push_back(mk(ST_TICK_NONE, 0, 1));
          else while (q_cnt > 0 && q_dl[0] == 0) begin
            id = q_id[0];
            drop_at(0);
            pending_q.push_back(mk(ST_EXPIRED, id, q_cnt == 0 || q_dl[0] != 0));
          end
        end
      end
      CMD_CANCEL: begin
        p = -1;
        for (int i = 0; i < q_cnt && p < 0; i++) if (q_id[i] == id) p = i;
        if (p < 0) pending_q.push_back(mk(ST_NOT_FOUND, 0, 1));
        else begin
          if (p + 1 < q_cnt) begin
            s = q_dl[p+1] + q_dl[p];
            q_dl[p+1] = s[16] ? 16'hffff : s[15:0];
          end
          drop_at(p);
          pending_q.push_back(mk(ST_CANCELLED, id, 1));
        end
      end
      default: pending_q.push_back(mk(ST_NOT_FOUND, 0, 1));
    endcase
  endtask

  task automatic send_beat(logic [1:0] c, logic [15:0] id, logic [15:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    command_i <= c; waiter_id_i <= id; wait_ticks_i <= w; in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_queue(c, id, w);
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else out_ready_i <= $urandom_range(99) >= recv_stall_pct;
  end

  always @(posedge clk_i) begin
    beat_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat st=%0d id=%h", status_o, result_id_o);
      end else begin
        e = pending_q.pop_front();
        if (status_o !== e.st || result_id_o !== e.id || last_o !== e.fin ||
            occupancy_o !== e.occ) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp st=%0d id=%h last=%b occ=%0d got st=%0d id=%h last=%b occ=%0d",
                     e.st, e.id, e.fin, e.occ, status_o, result_id_o, last_o, occupancy_o);
        end
      end
    end
  end

  task automatic drain_queue();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_beat(CMD_TICK, 16'h0, 16'h0);
    send_beat(CMD_INSERT, 16'h1234, 16'h0);
    send_beat(CMD_INSERT, 16'hffff, 16'hffff);
    send_beat(CMD_INSERT, 16'h0000, 16'd1);
    send_beat(CMD_INSERT, 16'h00a1, 16'd3);
    send_beat(CMD_INSERT, 16'h00a2, 16'd3);
    send_beat(CMD_INSERT, 16'h00a1, 16'd5);
    send_beat(CMD_CANCEL, 16'h00a1, 16'h0);
    send_beat(CMD_CANCEL, 16'h5555, 16'h0);
    send_beat(2'd3, 16'haaaa, 16'h5555);
    send_beat(CMD_CANCEL, 16'h0000, 16'h0);
    send_beat(CMD_TICK, 16'h0, 16'h0);
    send_beat(CMD_TICK, 16'h0, 16'h0);
    send_beat(CMD_TICK, 16'h0, 16'h0);
    send_beat(CMD_INSERT, 16'h0b0b, 16'hfff0);
    send_beat(CMD_CANCEL, 16'h00a1, 16'h0);
    send_beat(CMD_CANCEL, 16'hffff, 16'h0);
    send_beat(CMD_CANCEL, 16'h0b0b, 16'h0);
    drain_queue();
  endtask

  task automatic test_fill();
    for (int i = 0; i < 17; i++) send_beat(CMD_INSERT, 16'(i + 1), 16'(1 + i % 3));
    send_beat(CMD_INSERT, 16'h7777, 16'd2);
    for (int i = 0; i < 3; i++) send_beat(CMD_TICK, 16'h0, 16'h0);
    drain_queue();
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40)
        send_beat(CMD_INSERT, 16'($urandom_range(15)),
                  $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(6)));
      else if (r < 70) send_beat(CMD_TICK, 16'($urandom), 16'($urandom));
      else if (r < 90) send_beat(CMD_CANCEL, 16'($urandom_range(15)), 16'($urandom));
      else if (r < 95) send_beat(CMD_CANCEL, 16'($urandom), 16'($urandom));
      else send_beat(2'd3, 16'($urandom), 16'($urandom));
    end
    drain_queue();
  endtask

  task automatic test_backpressure();
    hold_cycles <= 300;
    for (int i = 0; i < 20; i++) send_beat(CMD_INSERT, 16'($urandom), 16'($urandom_range(1, 4)));
    for (int i = 0; i < 5; i++) send_beat(CMD_TICK, 16'h0, 16'h0);
    drain_queue();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill();
    test_backpressure();
    test_random(26);
    send_idle_pct = 68;
    test_random(26);
    send_idle_pct = 0; recv_stall_pct = 68;
    test_random(26);
    send_idle_pct = 37; recv_stall_pct = 37;
    test_random(26);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

>>> delta_timeout_queue.f
+incdir+rtl
rtl/dtq_pkg.sv
rtl/dtq_cell.sv
rtl/delta_timeout_queue.sv
verif/tb_delta_timeout_queue.sv
